// ----- src/mlch_pkg.sv -----
`timescale 1ns / 1ps
// mlch_pkg: shared types and constants of the multi-length context histogram
// used by mlch_rmw_unit and multi_length_context_histogram_unit, no dependencies
package mlch_pkg;

    // request codes on the input channel
    localparam logic [1:0] REQ_STREAM = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    // fixed field widths
    localparam int REQ_W      = 2;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 13;
    localparam int OUT_W      = 32;
    localparam int CFG_LEN_W  = 4;
    localparam int BIT_IDX_W  = 3;

    // configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_CONTEXT_LEN = 2'd0;
    localparam logic [CFG_LEN_W-1:0]  CONTEXT_LEN_RESET = 4'd8;

    // commands from the sequencer to the counter memory unit
    typedef struct packed {
        logic rd;    // plain read, data registered next cycle
        logic inc;   // read-modify-write increment
        logic clr;   // write zero
    } t_mem_ctl;

endpackage

// ----- src/mlch_rmw_unit.sv -----
`timescale 1ns / 1ps
// mlch_rmw_unit: counter memory with the shared saturating increment unit
// depends on mlch_pkg (t_mem_ctl)
module mlch_rmw_unit #(
    parameter int ADDR_W      = 13,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mlch_pkg::t_mem_ctl     i_ctl,
    input  logic [ADDR_W-1:0]      i_addr,
    output logic [COUNT_WIDTH-1:0] o_rd_data
);
    import mlch_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_q;

    // writeback stage of the increment
    logic                   r_wb_vld;
    logic [ADDR_W-1:0]      r_wb_addr;
    logic                   r_fwd;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;
    logic [COUNT_WIDTH-1:0] old_val;

    // old value: bypass when the previous writeback hit the same entry
    assign old_val = r_fwd ? r_fwd_data : r_q;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wb_addr;
        wr_data = '0;
        if (i_ctl.clr) begin
            wr_en   = 1'b1;
            wr_addr = i_addr;
        end else if (r_wb_vld) begin
            wr_en   = 1'b1;
            wr_data = (old_val == '1) ? old_val : old_val + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.rd || i_ctl.inc) begin
            r_q <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            r_wb_vld <= i_ctl.inc;
            r_fwd    <= i_ctl.inc && wr_en && (wr_addr == i_addr);
        end
        r_wb_addr  <= i_addr;
        r_fwd_data <= wr_data;
    end

    assign o_rd_data = r_q;

    // a clearing sweep never meets a pending increment
    a_clr_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |-> !r_wb_vld)
        else $error("clear write collides with increment writeback");

    // writeback only follows an increment command
    a_wb_after_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wb_vld |-> $past(i_ctl.inc))
        else $error("writeback without increment");

    // bypass only between two back-to-back increments
    a_fwd_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> (r_wb_vld && $past(r_wb_vld)))
        else $error("bypass without a preceding writeback");

endmodule

// ----- src/multi_length_context_histogram_unit.sv -----
`timescale 1ns / 1ps
// multi_length_context_histogram_unit: top level, configuration port and sequencer
// depends on mlch_pkg and mlch_rmw_unit
//
// Counts bit patterns of every length 1..context_len in a bit stream fed as
// bytes, least significant bit first. Each input word is a request: a stream
// byte, a read of one counter, or a clear of all counters. The counters live in
// one memory of 2^(MAX_CONTEXT+1) entries with one read and one write port and
// are updated by one shared saturating incrementer, one counter per cycle. Per
// bit the context is shifted in ST_BIT, then ST_LEN issues one increment per
// pattern length and ST_DRAIN takes the last writeback. Bits still inside the
// warm-up skip the increments. A read result is registered at the memory
// output and then in the output register, which waits on the output stall.
// After reset and after every clear request the block sweeps all
// 2^(MAX_CONTEXT+1) entries (8192 by default) to zero, one entry a cycle;
// no input word is taken meanwhile, configuration writes are. Write context_len
// only while the block is idle; 0 acts as 1 and values above MAX_CONTEXT act as
// MAX_CONTEXT. Only read requests give a result word.
module multi_length_context_histogram_unit #(
    parameter int MAX_CONTEXT = 12,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mlch_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mlch_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mlch_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [mlch_pkg::REQ_W-1:0]          i_req_type,
    input  logic [mlch_pkg::BYTE_W-1:0]         i_data_byte,
    input  logic                                i_first_byte,
    input  logic [mlch_pkg::IDX_W-1:0]          i_read_index,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [mlch_pkg::OUT_W-1:0]          o_count_value,
    output logic                                o_out_of_range
);
    import mlch_pkg::*;

    localparam int ADDR_W = MAX_CONTEXT + 1;
    localparam int LEN_W  = $clog2(MAX_CONTEXT + 1);
    localparam int CMP_W  = (IDX_W > ADDR_W + 1) ? IDX_W : ADDR_W + 1;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_BIT,
        ST_LEN,
        ST_DRAIN
    } t_state;

    t_state                 r_state;
    logic [CFG_LEN_W-1:0]   r_ctx_len;
    logic [MAX_CONTEXT-1:0] r_ctx;        // newest bit at the top
    logic [LEN_W-1:0]       r_warm;
    logic [BYTE_W-1:0]      r_byte;
    logic [BIT_IDX_W-1:0]   r_bit_idx;
    logic [LEN_W-1:0]       r_len;
    logic [MAX_CONTEXT-1:0] r_scan;       // context copy, next pattern bit at top
    logic [ADDR_W-1:0]      r_addr;       // address of the previous length
    logic [ADDR_W-1:0]      r_clr_addr;
    logic                   r_rd_oor;     // range flag of the read in flight
    logic                   r_out_vld;
    logic [OUT_W-1:0]       r_count;
    logic                   r_oor;

    logic [LEN_W-1:0]       eff_n;
    logic [LEN_W-1:0]       warm_new;
    logic [MAX_CONTEXT-1:0] ctx_new;
    logic                   cur_bit;
    logic [ADDR_W-1:0]      cur_addr;
    logic [CMP_W-1:0]       idx_ext;
    logic [CMP_W-1:0]       used;
    logic                   in_acc;
    logic                   cfg_wr;
    logic                   last_bit;
    t_mem_ctl               mem_ctl;
    logic [ADDR_W-1:0]      mem_addr;
    logic [COUNT_WIDTH-1:0] mem_rd_data;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == ADDR_CONTEXT_LEN) ? APB_DATA_W'(r_ctx_len) : '0;

    // effective context length, clamped to 1..MAX_CONTEXT
    always_comb begin
        if (r_ctx_len == '0) begin
            eff_n = LEN_W'(1);
        end else if ({1'b0, r_ctx_len} > 5'(MAX_CONTEXT)) begin
            eff_n = LEN_W'(MAX_CONTEXT);
        end else begin
            eff_n = LEN_W'(r_ctx_len);
        end
    end

    // ---------------- datapath helpers ----------------
    assign in_acc   = i_in_valid && !o_in_stall;
    assign last_bit = (r_bit_idx == '1);

    // shift the new bit in at the top
    assign ctx_new  = {r_byte[r_bit_idx], r_ctx[MAX_CONTEXT-1:1]};
    assign warm_new = (r_warm < LEN_W'(MAX_CONTEXT)) ? r_warm + LEN_W'(1) : r_warm;

    // address of length L from length L-1: 2*addr + 2 + next bit
    // starting from all ones gives the length-one address
    assign cur_bit  = r_scan[MAX_CONTEXT-1];
    assign cur_addr = (r_addr << 1) + ADDR_W'(2) + ADDR_W'(cur_bit);

    // used table size 2^(n+1)-2, always below the memory depth
    assign idx_ext  = CMP_W'(i_read_index);
    assign used     = (CMP_W'(2) << eff_n) - CMP_W'(2);

    // memory commands
    always_comb begin
        mem_ctl  = '0;
        mem_addr = idx_ext[ADDR_W-1:0];
        unique case (r_state)
            ST_CLR: begin
                mem_ctl.clr = 1'b1;
                mem_addr    = r_clr_addr;
            end
            ST_IDLE: begin
                mem_ctl.rd = in_acc && (i_req_type == REQ_READ);
            end
            ST_LEN: begin
                mem_ctl.inc = 1'b1;
                mem_addr    = cur_addr;
            end
            default: begin
            end
        endcase
    end

    mlch_rmw_unit #(
        .ADDR_W      (ADDR_W),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_rmw (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mem_ctl),
        .i_addr    (mem_addr),
        .o_rd_data (mem_rd_data)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLR;
            r_clr_addr <= '0;
            r_ctx_len  <= CONTEXT_LEN_RESET;
            r_ctx      <= '0;
            r_warm     <= '0;
            r_bit_idx  <= '0;
            r_len      <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            if (cfg_wr && paddr == ADDR_CONTEXT_LEN) begin
                r_ctx_len <= pwdata[CFG_LEN_W-1:0];
            end
            // the read state refills the output register itself
            if (r_out_vld && !i_out_stall && r_state != ST_RD) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == '1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_acc) begin
                        case (i_req_type)
                            REQ_STREAM: begin
                                if (i_first_byte) begin
                                    r_ctx  <= '0;
                                    r_warm <= '0;
                                end
                                r_byte    <= i_data_byte;
                                r_bit_idx <= '0;
                                r_state   <= ST_BIT;
                            end
                            REQ_READ: begin
                                r_rd_oor <= (idx_ext >= used);
                                r_state  <= ST_RD;
                            end
                            REQ_CLEAR: begin
                                r_clr_addr <= '0;
                                r_state    <= ST_CLR;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RD: begin
                    // memory data holds until the output register frees
                    if (!r_out_vld || !i_out_stall) begin
                        r_out_vld <= 1'b1;
                        r_oor     <= r_rd_oor;
                        r_count   <= r_rd_oor ? '0 : OUT_W'(mem_rd_data);
                        r_state   <= ST_IDLE;
                    end
                end
                ST_BIT: begin
                    r_ctx  <= ctx_new;
                    r_warm <= warm_new;
                    if (warm_new >= eff_n) begin
                        r_len   <= LEN_W'(1);
                        r_scan  <= ctx_new;
                        r_addr  <= '1;
                        r_state <= ST_LEN;
                    end else if (last_bit) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_bit_idx <= r_bit_idx + BIT_IDX_W'(1);
                    end
                end
                ST_LEN: begin
                    r_addr <= cur_addr;
                    r_scan <= r_scan << 1;
                    if (r_len == eff_n) begin
                        if (last_bit) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_bit_idx <= r_bit_idx + BIT_IDX_W'(1);
                            r_state   <= ST_BIT;
                        end
                    end else begin
                        r_len <= r_len + LEN_W'(1);
                    end
                end
                ST_DRAIN: begin
                    // last increment writes back here
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_count_value  = r_count;
    assign o_out_of_range = r_oor;

    // ---------------- assertions ----------------
    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN) |-> (r_len != '0 && r_len <= eff_n))
        else $error("pattern length outside 1..context_len");

    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_req_type == REQ_READ) |=> (r_state == ST_RD))
        else $error("read request did not reach the read state");

    a_drain_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($past(r_state) != ST_LEN))
        else $error("idle entered with an increment still in flight");

endmodule

// ----- verif/multi_length_context_histogram_unit_tb.sv -----
`timescale 1ns / 1ps
// multi_length_context_histogram_unit_tb: self-checking testbench of the histogram unit
// depends on mlch_pkg and multi_length_context_histogram_unit, nothing else
module multi_length_context_histogram_unit_tb;

    localparam int MAX_CTX     = 12;
    localparam int COUNT_W     = 32;
    localparam int TABLE_DEPTH = 1 << (MAX_CTX + 1);
    localparam int CLK_HALF_NS = 6;
    // time limit on the whole run, after which the block is taken to have stopped
    localparam longint RUN_LIMIT_NS = 64'd20_000_000;
    // quiet time after a fence, long enough for one stream word at the longest context
    localparam int SETTLE_CYCLES = 150;
    localparam int PHASE_WORDS   = 80;

    // code the package leaves unnamed, the block must ignore it
    localparam logic [mlch_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               oor;
    } t_read_word;

    // dut connections, all inputs start at known values
    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              psel = 1'b0;
    logic                              penable = 1'b0;
    logic                              pwrite = 1'b0;
    logic [mlch_pkg::APB_ADDR_W-1:0]   paddr = '0;
    logic [mlch_pkg::APB_DATA_W-1:0]   pwdata = '0;
    logic [mlch_pkg::APB_DATA_W-1:0]   prdata;
    logic                              pready;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_stall;
    logic [mlch_pkg::REQ_W-1:0]        i_req_type = '0;
    logic [mlch_pkg::BYTE_W-1:0]       i_data_byte = '0;
    logic                              i_first_byte = 1'b0;
    logic [mlch_pkg::IDX_W-1:0]        i_read_index = '0;
    logic                              o_out_valid;
    logic                              i_out_stall = 1'b0;
    logic [mlch_pkg::OUT_W-1:0]        o_count_value;
    logic                              o_out_of_range;

    // shadow copy of the histogram state
    logic [COUNT_W-1:0]                hist_mem [0:TABLE_DEPTH-1];
    logic [MAX_CTX-1:0]                ctx_shift;
    logic [3:0]                        warm_cnt;
    logic [mlch_pkg::CFG_LEN_W-1:0]    len_reg;

    // read results still owed by the block, oldest first
    t_read_word                        pending_reads[$];
    t_read_word                        exp_word;

    int unsigned                       err_cnt = 0;
    int unsigned                       words_sent = 0;
    int unsigned                       reads_checked = 0;
    int unsigned                       clears_sent = 0;
    logic [15:0]                       lens_written = '0;

    // idle shaping, a set bit turns the random gaps off on that side
    bit                                in_quiet = 1'b0;
    bit                                out_quiet = 1'b0;

    multi_length_context_histogram_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_read_index   (i_read_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_count_value  (o_count_value),
        .o_out_of_range (o_out_of_range)
    );

    initial begin
        forever begin
            #(CLK_HALF_NS) i_clk = ~i_clk;
        end
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: timeout, block stopped making progress", $time);
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------
    // histogram predictor
    // ---------------------------------------------------------------

    // register value as the block uses it: 0 acts as 1, large values clip
    function automatic int unsigned active_len();
        if (len_reg == 0) begin
            return 1;
        end
        if (len_reg > MAX_CTX) begin
            return MAX_CTX;
        end
        return len_reg;
    endfunction

    // size of the part of the table that the current length uses
    function automatic int unsigned used_entries();
        return (1 << (active_len() + 1)) - 2;
    endfunction

    // one stream bit: shift in at the top, then, once warmed up, bump every pattern length
    task automatic hist_take_bit(input logic b);
        int unsigned n;
        int unsigned pat;
        int unsigned idx;
        n = active_len();
        ctx_shift = {b, ctx_shift[MAX_CTX-1:1]};
        if (warm_cnt < MAX_CTX) begin
            warm_cnt++;
        end
        if (warm_cnt >= n) begin
            for (int l = 1; l <= n; l++) begin
                pat = int'(ctx_shift) >> (MAX_CTX - l);
                idx = (((1 << l) - 2) + pat) & (TABLE_DEPTH - 1);
                if (hist_mem[idx] != {COUNT_W{1'b1}}) begin
                    hist_mem[idx] = hist_mem[idx] + 1'b1;
                end
            end
        end
    endtask

    task automatic hist_clear_table();
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            hist_mem[k] = '0;
        end
    endtask

    // apply one accepted word to the shadow state, queue a read result
    task automatic hist_apply_word(input logic [mlch_pkg::REQ_W-1:0] req,
                                   input logic [mlch_pkg::BYTE_W-1:0] db,
                                   input logic fb,
                                   input logic [mlch_pkg::IDX_W-1:0] ri);
        t_read_word r;
        case (req)
            mlch_pkg::REQ_STREAM: begin
                if (fb) begin
                    ctx_shift = '0;
                    warm_cnt  = '0;
                end
                for (int k = 0; k < mlch_pkg::BYTE_W; k++) begin
                    hist_take_bit(db[k]);
                end
            end
            mlch_pkg::REQ_READ: begin
                if (ri >= used_entries()) begin
                    r.count = '0;
                    r.oor   = 1'b1;
                end else begin
                    r.count = hist_mem[ri];
                    r.oor   = 1'b0;
                end
                pending_reads.insert(pending_reads.size(), r);
            end
            mlch_pkg::REQ_CLEAR: begin
                hist_clear_table();
                clears_sent++;
            end
            default: begin
                // unused code, no effect
            end
        endcase
    endtask

    // ---------------------------------------------------------------
    // result checker, one word per accepting edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_reads.size() == 0) begin
                $display("%0t: result word with none expected, expected none, got %0d/%0b",
                         $time, o_count_value, o_out_of_range);
                err_cnt++;
            end else begin
                exp_word = pending_reads.pop_front();
                reads_checked++;
                if (o_count_value !== exp_word.count) begin
                    $display("%0t: count_value mismatch, expected %0d, got %0d",
                             $time, exp_word.count, o_count_value);
                    err_cnt++;
                end
                if (o_out_of_range !== exp_word.oor) begin
                    $display("%0t: out_of_range mismatch, expected %0b, got %0b",
                             $time, exp_word.oor, o_out_of_range);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result side back-pressure: alternating free and stalled runs
    // ---------------------------------------------------------------
    function automatic int unsigned pick_run(input bit long_ok);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97 || !long_ok) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    initial begin
        int unsigned n;
        forever begin
            n = 1 + pick_run(1'b1);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            n = out_quiet ? 0 : pick_run(1'b1);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // request side driving
    // ---------------------------------------------------------------
    function automatic int unsigned pick_gap();
        if (in_quiet) begin
            return 0;
        end
        return pick_run(1'b1);
    endfunction

    // drop valid for a gap of length n, nothing when n is zero
    task automatic hold_off_input(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    // present one word and wait until the block takes it
    task automatic send_word(input logic [mlch_pkg::REQ_W-1:0] req,
                             input logic [mlch_pkg::BYTE_W-1:0] db,
                             input logic fb,
                             input logic [mlch_pkg::IDX_W-1:0] ri);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_data_byte  <= db;
        i_first_byte <= fb;
        i_read_index <= ri;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        hist_apply_word(req, db, fb, ri);
        words_sent++;
    endtask

    task automatic send_stream(input logic [7:0] db, input logic fb);
        send_word(mlch_pkg::REQ_STREAM, db, fb, 13'($urandom));
    endtask

    task automatic send_read(input logic [12:0] ri);
        send_word(mlch_pkg::REQ_READ, 8'($urandom), 1'($urandom), ri);
    endtask

    // a read acts as a fence: its result means all earlier work is done
    task automatic settle_block();
        send_read(13'($urandom_range(0, used_entries() - 1)));
        hold_off_input(1);
        while (pending_reads.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= mlch_pkg::ADDR_CONTEXT_LEN;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pready) break;
        end
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write context_len (upper data bits random), then read it back
    task automatic set_context_len(input logic [3:0] len);
        logic [31:0] wd;
        logic [31:0] rd;
        wd = {28'($urandom), len};
        apb_access(1'b1, wd, rd);
        len_reg = len;
        lens_written[len] = 1'b1;
        apb_access(1'b0, '0, rd);
        if (rd !== {28'd0, len}) begin
            $display("%0t: context_len readback mismatch, expected %0d, got %0d",
                     $time, len, rd);
            err_cnt++;
        end
    endtask

    // ---------------------------------------------------------------
    // directed tests
    // ---------------------------------------------------------------

    // after reset: default length 8, empty table, index past the table
    task automatic test_reset_state();
        logic [31:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== {28'd0, mlch_pkg::CONTEXT_LEN_RESET}) begin
            $display("%0t: context_len reset value mismatch, expected %0d, got %0d",
                     $time, mlch_pkg::CONTEXT_LEN_RESET, rd);
            err_cnt++;
        end
        send_read(13'd0);
        send_read(13'h1FFF);
    endtask

    // all-zero and all-one bytes, restart in the middle, edge of used table
    task automatic test_stream_extremes();
        send_stream(8'h00, 1'b1);
        send_stream(8'hFF, 1'b0);
        send_stream(8'h5A, 1'b1);
        send_read(13'd0);
        send_read(13'(used_entries() - 1));
        send_read(13'(used_entries()));
    endtask

    // length 0 acts as 1, lengths above the maximum clip to it
    task automatic test_config_extremes();
        settle_block();
        set_context_len(4'd0);
        send_stream(8'hFF, 1'b1);
        send_read(13'd1);
        send_read(13'd2);
        settle_block();
        set_context_len(4'd15);
        send_stream(8'h0F, 1'b1);
        send_stream(8'hF0, 1'b0);
        send_read(13'd8189);
        send_read(13'd8190);
        settle_block();
        set_context_len(4'd12);
    endtask

    // new length applies from the next bit, context carries over
    task automatic test_length_change();
        settle_block();
        set_context_len(4'd4);
        send_stream(8'h3C, 1'b1);
        settle_block();
        set_context_len(4'd2);
        send_stream(8'hC3, 1'b0);
        send_read(13'd5);
    endtask

    // clear empties the table but keeps context, first flag ignored
    task automatic test_clear();
        send_word(mlch_pkg::REQ_CLEAR, 8'hFF, 1'b1, 13'h1FFF);
        send_word(mlch_pkg::REQ_READ, 8'h00, 1'b1, 13'd3);
        send_stream(8'h81, 1'b0);
        send_read(13'd0);
    endtask

    // unused request code must leave no trace
    task automatic test_unused_code();
        send_word(REQ_UNUSED, 8'hFF, 1'b1, 13'h1FFF);
        send_read(13'd1);
    endtask

    // ---------------------------------------------------------------
    // random traffic
    // ---------------------------------------------------------------
    function automatic logic [7:0] pick_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return 8'($urandom);
    endfunction

    function automatic logic [12:0] pick_index();
        int unsigned r;
        int unsigned u;
        u = used_entries();
        r = $urandom_range(0, 99);
        if (r < 70) return 13'($urandom_range(0, u - 1));
        if (r < 73) return 13'(u - 1);
        if (r < 76) return 13'(u);
        if (r < 78) return 13'h1FFF;
        if (r < 80) return 13'd0;
        return 13'($urandom_range(0, TABLE_DEPTH - 1));
    endfunction

    // one phase at a fixed length, mostly restart-led byte runs then reads
    task automatic run_random_phase(input logic [3:0] len, input int unsigned words);
        int unsigned cnt;
        int unsigned r;
        int unsigned nb;
        cnt = 0;
        settle_block();
        set_context_len(len);
        while (cnt < words) begin
            // now and then a stretch with no idling on one or both sides
            if ($urandom_range(0, 7) == 0) begin
                in_quiet  = $urandom_range(0, 1);
                out_quiet = $urandom_range(0, 1);
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                nb = $urandom_range(1, 5);
                hold_off_input(pick_gap());
                send_stream(pick_byte(), 1'b1);
                repeat (nb) begin
                    hold_off_input(pick_gap());
                    send_stream(pick_byte(), 1'b0);
                end
                nb = $urandom_range(1, 3);
                repeat (nb) begin
                    hold_off_input(pick_gap());
                    send_read(pick_index());
                end
                cnt += 1 + 5;
            end else if (r < 85) begin
                hold_off_input(pick_gap());
                send_read(pick_index());
                cnt++;
            end else if (r < 93) begin
                // byte with no restart, or a restart out of place
                hold_off_input(pick_gap());
                send_stream(pick_byte(), 1'($urandom));
                cnt++;
            end else if (r < 95) begin
                hold_off_input(pick_gap());
                send_word(mlch_pkg::REQ_CLEAR, 8'($urandom), 1'($urandom), 13'($urandom));
                cnt++;
            end else begin
                hold_off_input(pick_gap());
                send_word(REQ_UNUSED, 8'($urandom), 1'($urandom), 13'($urandom));
            end
        end
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [3:0] lens [0:9];
        lens = '{4'd12, 4'd1, 4'd0, 4'd15, 4'd3, 4'd13, 4'd8,
                 4'($urandom_range(2, 11)), 4'd12, 4'($urandom_range(0, 15))};
        foreach (lens[k]) begin
            run_random_phase(lens[k], PHASE_WORDS);
        end
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        hist_clear_table();
        ctx_shift = '0;
        warm_cnt  = '0;
        len_reg   = mlch_pkg::CONTEXT_LEN_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_stream_extremes();
        test_config_extremes();
        test_length_change();
        test_clear();
        test_unused_code();
        test_random_traffic();

        // drain everything still in flight, then let the block go quiet
        hold_off_input(1);
        while (pending_reads.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d words, checked %0d read results, %0d table clears",
                 words_sent, reads_checked, clears_sent);
        $display("context_len values written (bit mask): %016b", lens_written);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
